### sv/utf8d_pkg.sv
// Shared types, status codes and constants for the UTF-8 validating decoder.
`default_nettype none
package utf8d_pkg;

	// Result status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_LEAD  = 3'd1;
	localparam logic [2:0] ST_BAD_CONT  = 3'd2;
	localparam logic [2:0] ST_OVERLONG  = 3'd3;
	localparam logic [2:0] ST_RANGE     = 3'd4;
	localparam logic [2:0] ST_TRUNCATED = 3'd5;
	localparam logic [2:0] ST_LEAD_LONG = 3'd6;

	// Code point constants
	localparam int          CP_W       = 21;
	localparam logic [20:0] CP_REPL    = 21'h00FFFD;
	localparam logic [20:0] CP_MAX     = 21'h10FFFF;
	localparam logic [20:0] SURR_LO    = 21'h00D800;
	localparam logic [20:0] SURR_HI    = 21'h00DFFF;
	localparam logic [20:0] MAX_1BYTE  = 21'h00007F;
	localparam logic [20:0] MAX_2BYTE  = 21'h0007FF;
	localparam logic [20:0] MAX_3BYTE  = 21'h00FFFF;

	// Most results one byte can cause, and the counter width for it
	localparam int RES_MAX = 4;
	localparam int CNT_W   = 3;

	localparam logic REPLACE_RESET = 1'b1;

	// One result as it leaves the block
	typedef struct packed {
		logic [20:0] cp;
		logic [2:0]  st;
		logic        last;
	} res_t;

	// Sequence state carried from byte to byte
	typedef struct packed {
		logic [20:0] pv;
		logic [1:0]  pend;
		logic [7:0]  lead;
		logic        abort;
	} dec_state_t;

	// Total sequence length announced by a lead byte; 5 means too long
	function automatic logic [2:0] seq_len(input logic [7:0] lead);
		logic [2:0] len;
		if (lead[7:5] == 3'b110) len = 3'd2;
		else if (lead[7:4] == 4'b1110) len = 3'd3;
		else if (lead[7:3] == 5'b11110) len = 3'd4;
		else len = 3'd5;
		return len;
	endfunction

endpackage
`default_nettype wire

### sv/utf8d_ifs.sv
// Request channels of the decoder: input bytes, results and the mode register write.
`default_nettype none
interface utf8d_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_buffer;
	modport source(output valid, data_byte, end_of_buffer, input ready);
	modport sink(input valid, data_byte, end_of_buffer, output ready);
endinterface

interface utf8d_res_if;
	logic        valid;
	logic        ready;
	logic [20:0] code_point;
	logic [2:0]  status;
	logic        run_last;
	modport source(output valid, code_point, status, run_last, input ready);
	modport sink(input valid, code_point, status, run_last, output ready);
endinterface

interface utf8d_cfg_if;
	logic valid;
	logic ready;
	logic replace_on_error;
	modport source(output valid, replace_on_error, input ready);
	modport sink(input valid, replace_on_error, output ready);
endinterface
`default_nettype wire

### sv/utf8d_decode.sv
// Single-byte decode step: next sequence state and the results the byte causes.
`default_nettype none
module utf8d_decode (
	input  wire utf8d_pkg::dec_state_t cur,
	input  wire                        replace,
	input  wire [7:0]                  b,
	input  wire                        eob,
	output utf8d_pkg::dec_state_t      nxt,
	output utf8d_pkg::res_t            res [utf8d_pkg::RES_MAX],
	output logic [utf8d_pkg::CNT_W-1:0] n_res
);

	logic        ascii, stray, s_open, s_err;
	logic [20:0] s_cp;
	logic [2:0]  s_st;
	logic [2:0]  i_cnt, len;
	logic [20:0] pvn, d;
	logic        complete, overlong, range_err;
	logic [2:0]  fail_st;
	logic [2:0]  slot;

	// Classify the byte as a possible start of a sequence
	always_comb begin
		ascii  = ~b[7];
		stray  = (b[7:6] == 2'b10);
		s_open = ~ascii & ~stray & ~eob;
		s_err  = ~ascii;
		s_cp   = ascii ? {13'd0, b} : utf8d_pkg::CP_REPL;
		if (ascii) s_st = utf8d_pkg::ST_OK;
		else if (stray) s_st = utf8d_pkg::ST_BAD_LEAD;
		else s_st = utf8d_pkg::ST_TRUNCATED;
	end

	// Assemble the value of a continuation byte and check the completed form
	always_comb begin
		i_cnt = {1'b0, cur.pend} + 3'd1;
		len   = utf8d_pkg::seq_len(cur.lead);
		pvn   = {cur.pv[14:0], b[5:0]};
		complete = (i_cnt == len - 3'd1);
		unique case (len)
			3'd2:    d = {10'd0, cur.lead[4:0], pvn[5:0]};
			3'd3:    d = {5'd0, cur.lead[3:0], pvn[11:0]};
			default: d = {cur.lead[2:0], pvn[17:0]};
		endcase
		unique case (i_cnt)
			3'd1:    overlong = (d <= utf8d_pkg::MAX_1BYTE);
			3'd2:    overlong = (d <= utf8d_pkg::MAX_2BYTE);
			default: overlong = (d <= utf8d_pkg::MAX_3BYTE);
		endcase
		range_err = ((i_cnt == 3'd2) && (d >= utf8d_pkg::SURR_LO) &&
				(d <= utf8d_pkg::SURR_HI)) ||
			((i_cnt == 3'd3) && (d > utf8d_pkg::CP_MAX));
		fail_st = overlong ? utf8d_pkg::ST_OVERLONG : utf8d_pkg::ST_RANGE;
	end

	// Pick the results and the next state
	always_comb begin
		nxt   = cur;
		n_res = '0;
		slot  = {1'b0, cur.pend} + 3'd1;
		for (int k = 0; k < utf8d_pkg::RES_MAX; k++) begin
			res[k] = '{cp: utf8d_pkg::CP_REPL, st: utf8d_pkg::ST_BAD_LEAD, last: 1'b0};
		end
		if (cur.abort) begin
			// skip until the end of the buffer
			nxt.abort = ~eob;
		end else if (cur.lead == 8'd0) begin
			if (s_open) begin
				nxt.lead = b;
				nxt.pend = 2'd0;
				nxt.pv   = '0;
			end else begin
				res[0].cp = s_cp;
				res[0].st = s_st;
				n_res     = 3'd1;
				if (s_err && !replace) nxt.abort = ~eob;
			end
		end else if (b[7:6] != 2'b10) begin
			// bad continuation: report, then restart on this byte in replace mode
			res[0].st = utf8d_pkg::ST_BAD_CONT;
			nxt.pv    = '0;
			nxt.pend  = 2'd0;
			nxt.lead  = 8'd0;
			if (replace) begin
				if (s_open) begin
					nxt.lead = b;
					n_res    = slot;
				end else begin
					for (int k = 1; k < utf8d_pkg::RES_MAX; k++) begin
						if (slot == 3'(k)) begin
							res[k].cp = s_cp;
							res[k].st = s_st;
						end
					end
					n_res = slot + 3'd1;
				end
			end else begin
				n_res     = 3'd1;
				nxt.abort = ~eob;
			end
		end else begin
			nxt.pv   = '0;
			nxt.pend = 2'd0;
			nxt.lead = 8'd0;
			if (complete) begin
				if (overlong || range_err) begin
					res[0].st = fail_st;
					n_res     = replace ? (3'd1 + i_cnt) : 3'd1;
					if (!replace) nxt.abort = ~eob;
				end else begin
					res[0].cp = d;
					res[0].st = utf8d_pkg::ST_OK;
					n_res     = 3'd1;
				end
			end else if (i_cnt >= 3'd3) begin
				res[0].st = utf8d_pkg::ST_LEAD_LONG;
				n_res     = replace ? 3'd4 : 3'd1;
				if (!replace) nxt.abort = ~eob;
			end else if (eob) begin
				res[0].st = utf8d_pkg::ST_TRUNCATED;
				n_res     = replace ? (3'd1 + i_cnt) : 3'd1;
			end else begin
				// hold the sequence open
				nxt.lead = cur.lead;
				nxt.pend = i_cnt[1:0];
				nxt.pv   = pvn;
			end
		end
	end

endmodule
`default_nettype wire

### sv/utf8_validating_decoder.sv
// Top level of the UTF-8 validating decoder: input stage, sequence state and result queue.
`default_nettype none
// Streaming UTF-8 decoder with validation. Bytes enter on byte_ch, one per
// cycle while the result queue keeps up, with end_of_buffer on the last
// byte of a buffer; code points leave on result_ch with a status and
// run_last on the final result of each byte. A byte goes through an input
// register, is decoded against the held sequence state and drops its
// results (none to four) into a result queue, from which its first result
// can be taken. Input rate is one byte per cycle while each byte gives at
// most one result and result_ch is ready; during an error burst the input
// waits until the queue drains to its last entry. The mode register
// (replace_on_error, reset 1) is written on cfg_ch, which is always ready,
// and must only change while the block is idle.
module utf8_validating_decoder (
	input  wire                 clk,
	input  wire                 arst_n,
	utf8d_byte_if.sink          byte_ch,
	utf8d_res_if.source         result_ch,
	utf8d_cfg_if.sink           cfg_ch
);

	logic                          mode_q;
	logic                          v_s1;
	logic [7:0]                    byte_s1;
	logic                          eob_s1;
	utf8d_pkg::dec_state_t         dec_q, dec_nxt;
	utf8d_pkg::res_t               new_res [utf8d_pkg::RES_MAX];
	utf8d_pkg::res_t               load_res [utf8d_pkg::RES_MAX];
	logic [utf8d_pkg::CNT_W-1:0]   new_n;
	utf8d_pkg::res_t               q_q [utf8d_pkg::RES_MAX];
	logic [utf8d_pkg::CNT_W-1:0]   cnt_q;
	logic                          pop, q_free, advance, load, take;

	utf8d_decode u_decode (
		.cur     (dec_q),
		.replace (mode_q),
		.b       (byte_s1),
		.eob     (eob_s1),
		.nxt     (dec_nxt),
		.res     (new_res),
		.n_res   (new_n)
	);

	// Handshake control
	assign pop     = (cnt_q != '0) && result_ch.ready;
	assign q_free  = (cnt_q == '0) || ((cnt_q == 3'd1) && pop);
	assign advance = v_s1 && ((new_n == '0) || q_free);
	assign load    = advance && (new_n != '0);
	assign take    = byte_ch.valid && byte_ch.ready;

	assign byte_ch.ready = ~v_s1 | advance;
	assign cfg_ch.ready  = 1'b1;

	// Mode register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= utf8d_pkg::REPLACE_RESET;
		end else if (cfg_ch.valid) begin
			mode_q <= cfg_ch.replace_on_error;
		end
	end

	// Input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= 1'b1;
		end else if (advance) begin
			v_s1 <= 1'b0;
		end
	end

	// Input stage payload
	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= byte_ch.data_byte;
			eob_s1  <= byte_ch.end_of_buffer;
		end
	end

	// Advance the sequence state as each byte is decoded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_q <= '0;
		end else if (advance) begin
			dec_q <= dec_nxt;
		end
	end

	// Result count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= new_n;
		end else if (pop) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	// Mark the final result of each burst
	always_comb begin
		for (int k = 0; k < utf8d_pkg::RES_MAX; k++) begin
			load_res[k]      = new_res[k];
			load_res[k].last = (new_n == 3'(k + 1));
		end
	end

	// Load a new burst or shift the queue toward the port
	always_ff @(posedge clk) begin
		if (load) begin
			for (int k = 0; k < utf8d_pkg::RES_MAX; k++) begin
				q_q[k] <= load_res[k];
			end
		end else if (pop) begin
			for (int k = 0; k < utf8d_pkg::RES_MAX - 1; k++) begin
				q_q[k] <= q_q[k + 1];
			end
		end
	end

	assign result_ch.valid      = (cnt_q != '0);
	assign result_ch.code_point = q_q[0].cp;
	assign result_ch.status     = q_q[0].st;
	assign result_ch.run_last   = q_q[0].last;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd4)
		else $error("result count above four");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> ((cnt_q == 3'd0) || ((cnt_q == 3'd1) && pop)))
		else $error("burst loaded over pending results");
	a_tail_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 3'd1) |-> q_q[0].last)
		else $error("final queued result lacks run_last");
	a_abort_closed: assert property (@(posedge clk) disable iff (!arst_n)
		dec_q.abort |-> (dec_q.lead == 8'd0))
		else $error("sequence open while skipping");
	a_pend_open: assert property (@(posedge clk) disable iff (!arst_n)
		(dec_q.pend != 2'd0) |-> ((dec_q.lead != 8'd0) && (dec_q.pend != 2'd3)))
		else $error("pending count without open sequence");
`endif

endmodule
`default_nettype wire
